// File: rtl/core/iapsp_pkg.sv
package iapsp_pkg;

  // field widths
  localparam int NODE_W   = 7;
  localparam int WEIGHT_W = 20;
  localparam int COST_W   = 32;
  localparam int CFG_W    = 8;

  // defaults and fixed values
  localparam int                MAX_NODES_DEF  = 128;
  localparam logic [COST_W-1:0] DIST_INF       = 32'hFFFF_FFFF;
  localparam logic [CFG_W-1:0]  NODE_COUNT_RST = 8'd128;

  // request commands
  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_ADD   = 1'b1;

  typedef struct packed {
    logic                command;
    logic [NODE_W-1:0]   first_node;
    logic [NODE_W-1:0]   second_node;
    logic [WEIGHT_W-1:0] edge_weight;
  } req_t;

  typedef struct packed {
    logic              reachable;
    logic [COST_W-1:0] path_cost;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic clear_wr;
    logic rd_cd;
    logic rd_dc;
    logic cap_cd;
    logic wr_cd;
    logic wr_dc;
    logic copy_c;
    logic copy_d;
    logic row_rd;
    logic row_calc;
    logic sweep;
    logic respond;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic in_range;
    logic j_last;
    logic k_last;
    logic pipe_idle;
  } dp_sts_t;

  // add that sticks at infinity
  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (a >= DIST_INF || b >= DIST_INF || s >= {1'b0, DIST_INF}) begin
      sat_add = DIST_INF;
    end else begin
      sat_add = s[COST_W-1:0];
    end
  endfunction

endpackage

// File: rtl/core/incremental_all_pairs_shortest_path_unit.sv
// Incremental all-pairs shortest path unit.
// A request (command, first_node, second_node, edge_weight) is taken when
// start is high and busy is low. A query returns one result (reachable,
// path_cost) on result, marked by done for exactly one cycle; the receiver
// cannot hold it off. An add of an undirected edge returns nothing.
// The user writes node_count via cfg_write/cfg_data only while idle; the unit does not enforce it.
// Query: the pair is read in S_QREAD and the result registered from S_QRESP.
// Add with endpoints in range: the time is set by the distance matrix RAM,
// whose one read and one write port sweep one pair per cycle, plus the
// S_ROWRD and S_ROWCALC steps per matrix row that fetch the row terms and
// the S_COPYC and S_COPYD passes that copy the two endpoint rows.
// Add with an endpoint out of range: the unit returns to idle, matrix untouched.
// After reset the matrix RAM is cleared one word a cycle, diagonal zero and
// infinity elsewhere, all MAX_NODES * 2**clog2(MAX_NODES) words (16384 at the
// default size); busy stays high meanwhile; configuration writes are taken.
module incremental_all_pairs_shortest_path_unit import iapsp_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  req_t             request,
  output logic             busy,
  output logic             done,
  output rsp_t             result,
  input  logic             cfg_write,
  input  logic [CFG_W-1:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  iapsp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (request.command),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  iapsp_datapath #(.MAX_NODES(MAX_NODES)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .request   (request),
    .cmd       (cmd),
    .sts       (sts),
    .done      (done),
    .result    (result)
  );

`ifndef NO_ASSERTIONS
  // an accepted request always occupies the unit
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but unit not busy");

  // result cost agrees with the reachable flag
  a_result_form: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.reachable ? (result.path_cost != DIST_INF) : (result.path_cost == '0)))
    else $error("result cost does not match reachable flag");

  // the pair sweep only runs for an edge with both endpoints in range
  a_sweep_range: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep |-> sts.in_range)
    else $error("matrix sweep on an out of range edge");
`endif

endmodule

// File: rtl/core/iapsp_ram.sv
module iapsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/iapsp_datapath.sv
module iapsp_datapath import iapsp_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [CFG_W-1:0] cfg_data,
  input  req_t             request,
  input  dp_cmd_t          cmd,
  output dp_sts_t          sts,
  output logic             done,
  output rsp_t             result
);

  localparam int IW    = $clog2(MAX_NODES);
  localparam int DEPTH = MAX_NODES << IW;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = (IW + 1 > CFG_W) ? IW + 1 : CFG_W;
  localparam logic [CW-1:0] MAXN = CW'(MAX_NODES);
  localparam logic ROW_C = 1'b0;
  localparam logic ROW_D = 1'b1;

  logic [CFG_W-1:0]    node_count;
  req_t                req_q;
  logic [AW-1:0]       clr_cnt;
  logic [IW-1:0]       j;
  logic [IW-1:0]       k;
  logic [WEIGHT_W-1:0] wlow;
  logic [WEIGHT_W-1:0] dclow;
  logic [COST_W-1:0]   a1;
  logic [COST_W-1:0]   a2;
  logic                cp_v;
  logic                cp_sel;
  logic [IW-1:0]       cp_idx;
  logic                sw_v;
  logic [AW-1:0]       sw_addr;
  logic                s1_v;
  logic [AW-1:0]       s1_addr;
  logic [COST_W-1:0]   s1_m;
  logic [COST_W-1:0]   s1_p1;
  logic [COST_W-1:0]   s1_p2;

  logic [CW-1:0]       n_act;
  logic [IW-1:0]       c_idx;
  logic [IW-1:0]       d_idx;
  logic [COST_W-1:0]   clear_val;
  logic [COST_W-1:0]   best;
  logic                m_we;
  logic [AW-1:0]       m_waddr;
  logic [COST_W-1:0]   m_wdata;
  logic                m_re;
  logic [AW-1:0]       m_raddr;
  logic [COST_W-1:0]   m_rdata;
  logic                r_re;
  logic [IW-1:0]       r_raddr;
  logic [COST_W-1:0]   rc_rdata;
  logic [COST_W-1:0]   rd_rdata;
  logic [WEIGHT_W-1:0] low_now;
  logic                reach_now;

  // active node count and range check
  assign n_act = (CW'(node_count) > MAXN) ? MAXN : CW'(node_count);
  assign c_idx = IW'(req_q.first_node);
  assign d_idx = IW'(req_q.second_node);

  assign sts.in_range   = (CW'(req_q.first_node) < n_act) && (CW'(req_q.second_node) < n_act);
  assign sts.j_last     = (CW'(j) == n_act - CW'(1));
  assign sts.k_last     = (CW'(k) == n_act - CW'(1));
  assign sts.clear_done = (clr_cnt == AW'(DEPTH - 1));
  assign sts.pipe_idle  = !sw_v && !s1_v;

  // reset image: zero on the diagonal
  assign clear_val = (IW'(clr_cnt >> IW) == clr_cnt[IW-1:0]) ? '0 : DIST_INF;

  // lowered edge cost against the word just read
  assign low_now = ({{(COST_W-WEIGHT_W){1'b0}}, req_q.edge_weight} < m_rdata) ?
                   req_q.edge_weight : WEIGHT_W'(m_rdata);

  assign best      = (s1_p1 < s1_p2) ? s1_p1 : s1_p2;
  assign reach_now = sts.in_range && (m_rdata < DIST_INF);

  // matrix write port
  always_comb begin
    m_we    = 1'b0;
    m_waddr = clr_cnt;
    m_wdata = clear_val;
    if (cmd.clear_wr) begin
      m_we = 1'b1;
    end else if (cmd.wr_cd) begin
      m_we    = 1'b1;
      m_waddr = AW'({c_idx, d_idx});
      m_wdata = COST_W'(wlow);
    end else if (cmd.wr_dc) begin
      m_we    = 1'b1;
      m_waddr = AW'({d_idx, c_idx});
      m_wdata = COST_W'(dclow);
    end else if (s1_v && (best < s1_m)) begin
      m_we    = 1'b1;
      m_waddr = s1_addr;
      m_wdata = best;
    end
  end

  // matrix read port
  always_comb begin
    m_re    = cmd.rd_cd | cmd.rd_dc | cmd.copy_c | cmd.copy_d | cmd.sweep;
    m_raddr = '0;
    if (cmd.rd_cd) begin
      m_raddr = AW'({c_idx, d_idx});
    end else if (cmd.rd_dc) begin
      m_raddr = AW'({d_idx, c_idx});
    end else if (cmd.copy_c) begin
      m_raddr = AW'({c_idx, j});
    end else if (cmd.copy_d) begin
      m_raddr = AW'({d_idx, j});
    end else if (cmd.sweep) begin
      m_raddr = AW'({k, j});
    end
  end

  // row buffers read at k for the row setup, at j during the sweep
  assign r_re    = cmd.row_rd | cmd.sweep;
  assign r_raddr = cmd.row_rd ? k : j;

  iapsp_ram #(.WIDTH(COST_W), .DEPTH(DEPTH)) u_matrix (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .re    (m_re),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  iapsp_ram #(.WIDTH(COST_W), .DEPTH(MAX_NODES)) u_row_c (
    .clk   (clk),
    .we    (cp_v && (cp_sel == ROW_C)),
    .waddr (cp_idx),
    .wdata (m_rdata),
    .re    (r_re),
    .raddr (r_raddr),
    .rdata (rc_rdata)
  );

  iapsp_ram #(.WIDTH(COST_W), .DEPTH(MAX_NODES)) u_row_d (
    .clk   (clk),
    .we    (cp_v && (cp_sel == ROW_D)),
    .waddr (cp_idx),
    .wdata (m_rdata),
    .re    (r_re),
    .raddr (r_raddr),
    .rdata (rd_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RST;
      clr_cnt    <= '0;
      cp_v       <= 1'b0;
      sw_v       <= 1'b0;
      s1_v       <= 1'b0;
      done       <= 1'b0;
    end else begin
      if (cfg_write) begin
        node_count <= cfg_data;
      end
      if (cmd.clear_wr) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      cp_v <= cmd.copy_c | cmd.copy_d;
      sw_v <= cmd.sweep;
      s1_v <= sw_v;
      done <= cmd.respond;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_q <= request;
      j     <= '0;
      k     <= '0;
    end
    if (cmd.copy_c || cmd.copy_d || cmd.sweep) begin
      j <= sts.j_last ? '0 : j + IW'(1);
    end
    if (cmd.sweep && sts.j_last) begin
      k <= k + IW'(1);
    end
    cp_sel <= cmd.copy_d ? ROW_D : ROW_C;
    cp_idx <= j;
    if (cmd.cap_cd) begin
      wlow <= low_now;
    end
    if (cmd.wr_cd) begin
      dclow <= low_now;
    end
    if (cmd.row_calc) begin
      a1 <= sat_add(rc_rdata, COST_W'(wlow));
      a2 <= sat_add(rd_rdata, COST_W'(wlow));
    end
    // sweep pipe: read, path sums, compare and write
    sw_addr <= AW'({k, j});
    s1_addr <= sw_addr;
    s1_m    <= m_rdata;
    s1_p1   <= sat_add(a1, rd_rdata);
    s1_p2   <= sat_add(a2, rc_rdata);
    if (cmd.respond) begin
      result.reachable <= reach_now;
      result.path_cost <= reach_now ? m_rdata : '0;
    end
  end

endmodule

// File: rtl/core/iapsp_ctrl.sv
module iapsp_ctrl import iapsp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    command,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    busy
);

  typedef enum logic [14:0] {
    S_CLEAR   = 15'b000000000000001,
    S_IDLE    = 15'b000000000000010,
    S_QREAD   = 15'b000000000000100,
    S_QRESP   = 15'b000000000001000,
    S_EREAD1  = 15'b000000000010000,
    S_EREAD2  = 15'b000000000100000,
    S_EWR1    = 15'b000000001000000,
    S_EWR2    = 15'b000000010000000,
    S_COPYC   = 15'b000000100000000,
    S_COPYD   = 15'b000001000000000,
    S_PSETUP  = 15'b000010000000000,
    S_ROWRD   = 15'b000100000000000,
    S_ROWCALC = 15'b001000000000000,
    S_SWEEP   = 15'b010000000000000,
    S_DRAIN   = 15'b100000000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // sequencing of the matrix work
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = (command == CMD_ADD) ? S_EREAD1 : S_QREAD;
        end
      end
      S_QREAD: begin
        cmd.rd_cd  = 1'b1;
        state_next = S_QRESP;
      end
      S_QRESP: begin
        cmd.respond = 1'b1;
        state_next  = S_IDLE;
      end
      S_EREAD1: begin
        if (!sts.in_range) begin
          state_next = S_IDLE;
        end else begin
          cmd.rd_cd  = 1'b1;
          state_next = S_EREAD2;
        end
      end
      S_EREAD2: begin
        cmd.rd_dc  = 1'b1;
        cmd.cap_cd = 1'b1;
        state_next = S_EWR1;
      end
      S_EWR1: begin
        cmd.wr_cd  = 1'b1;
        state_next = S_EWR2;
      end
      S_EWR2: begin
        cmd.wr_dc  = 1'b1;
        state_next = S_COPYC;
      end
      S_COPYC: begin
        cmd.copy_c = 1'b1;
        if (sts.j_last) state_next = S_COPYD;
      end
      S_COPYD: begin
        cmd.copy_d = 1'b1;
        if (sts.j_last) state_next = S_PSETUP;
      end
      S_PSETUP: begin
        state_next = S_ROWRD;
      end
      S_ROWRD: begin
        cmd.row_rd = 1'b1;
        state_next = S_ROWCALC;
      end
      S_ROWCALC: begin
        cmd.row_calc = 1'b1;
        state_next   = S_SWEEP;
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.j_last) state_next = sts.k_last ? S_DRAIN : S_ROWRD;
      end
      S_DRAIN: begin
        if (sts.pipe_idle) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule
